// ----- rtl/htfd_pkg.sv -----
// htfd_pkg.sv: shared constants and a crc function for the humidity/temperature frame decoder
`timescale 1ns / 1ps

package htfd_pkg;

  // frame word layout on the input side
  localparam int unsigned InDataW  = 24;
  // result word layout on the output side, padded to whole bytes
  localparam int unsigned OutDataW = 24;

  localparam int unsigned RawW   = 16;
  localparam int unsigned ValueW = 15;
  localparam int unsigned HeldW  = 16;
  localparam int unsigned CoefW  = 15;
  localparam int unsigned ProdW  = RawW + CoefW;

  // crc-8 settings
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'h00;

  // status bits in the low data byte
  localparam logic [RawW-1:0] StatusMask = 16'h0003;

  // measurement kinds
  typedef enum logic {
    KIND_HUMIDITY    = 1'b0,
    KIND_TEMPERATURE = 1'b1
  } kind_e;

  // scale factors and offsets in hundredths, product taken >> 16
  localparam logic [CoefW-1:0]        HumCoef    = 15'd12500;
  localparam logic [CoefW-1:0]        TempCoef   = 15'd17572;
  localparam logic signed [HeldW-1:0] HumOffset  = -16'sd600;
  localparam logic signed [HeldW-1:0] TempOffset = -16'sd4685;

  // crc-8 over high byte then low byte, msb first, bit by bit
  function automatic logic [7:0] crc8_word(input logic [15:0] data);
    logic [7:0] crc;
    crc = CrcInit;
    for (int i = 15; i >= 0; i--) begin
      if (crc[7] ^ data[i]) begin
        crc = {crc[6:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/humidity_temperature_frame_decoder.sv -----
// humidity_temperature_frame_decoder.sv: top level of the sensor frame decoder
`timescale 1ns / 1ps

// Decodes one sensor reply frame per word: checks the two data bytes against
// the crc-8 check byte (poly 0x31, init 0), masks the two status bits and, if
// the crc matches and the reading is nonzero, converts it to hundredths of
// %RH or degree Celsius and holds it per kind. Every input word gives exactly
// one result word carrying the held value of its kind, the crc flag and the
// missing-sensor flag. The crc, one 15x16 constant-coefficient multiply and
// the offset add sit between the input port and the result register, so a
// result follows its word in the next cycle; the rate is one word per cycle
// while the output is not stalled. The result register frees itself in the
// same cycle it is taken, so input ready only drops while a result waits.
module humidity_temperature_frame_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // frame input
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] high_byte, [15:8] low_byte, [23:16] check_byte
  input  logic [htfd_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] measurement_kind
  input  logic                           s_axis_tuser_i,
  // result output
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [14:0] scaled_value, [15] sensor_missing, [16] check_ok, [23:17] zero
  output logic [htfd_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [0] reading_kind
  output logic                           m_axis_tuser_o
);

  import htfd_pkg::*;

  logic                     s_fire;
  kind_e                    kind;
  logic [7:0]               high_byte;
  logic [7:0]               low_byte;
  logic [7:0]               check_byte;
  logic [RawW-1:0]          raw;
  logic                     crc_ok;
  logic                     missing;
  logic [CoefW-1:0]         coef;
  logic [ProdW-1:0]         product;
  logic signed [HeldW-1:0]  offset;
  logic signed [HeldW-1:0]  converted;
  logic                     do_update;

  logic signed [HeldW-1:0]  held_hum_q, held_hum_d;
  logic signed [HeldW-1:0]  held_temp_q, held_temp_d;
  logic signed [HeldW-1:0]  held_sel;

  logic                     out_valid_q;
  logic [ValueW-1:0]        out_value_q;
  logic                     out_missing_q;
  logic                     out_ok_q;
  logic                     out_kind_q;

  // handshake: accept whenever the result register is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // unpack the frame word
  assign kind       = kind_e'(s_axis_tuser_i);
  assign high_byte  = s_axis_tdata_i[7:0];
  assign low_byte   = s_axis_tdata_i[15:8];
  assign check_byte = s_axis_tdata_i[23:16];

  // crc check and status masking
  assign raw     = {high_byte, low_byte} & ~StatusMask;
  assign crc_ok  = (crc8_word({high_byte, low_byte}) == check_byte);
  assign missing = (raw == '0);

  // conversion to hundredths, one shared multiply
  assign coef      = (kind == KIND_TEMPERATURE) ? TempCoef : HumCoef;
  assign offset    = (kind == KIND_TEMPERATURE) ? TempOffset : HumOffset;
  assign product   = ProdW'(raw) * ProdW'(coef);
  assign converted = offset + $signed({1'b0, product[ProdW-1:RawW]});
  assign do_update = s_fire && crc_ok && !missing;

  // next held values
  always_comb begin
    held_hum_d  = held_hum_q;
    held_temp_d = held_temp_q;
    if (do_update) begin
      if (kind == KIND_TEMPERATURE) begin
        held_temp_d = converted;
      end else begin
        held_hum_d = converted;
      end
    end
  end

  assign held_sel = (kind == KIND_TEMPERATURE) ? held_temp_d : held_hum_d;

  // held readings per kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_hum_q  <= '0;
      held_temp_q <= '0;
    end else begin
      held_hum_q  <= held_hum_d;
      held_temp_q <= held_temp_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_value_q   <= held_sel[ValueW-1:0];
      out_missing_q <= missing;
      out_ok_q      <= crc_ok;
      out_kind_q    <= s_axis_tuser_i;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {(OutDataW - ValueW - 2)'(0), out_ok_q, out_missing_q, out_value_q};

  // an accepted word always shows up on the output next cycle
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

  // a bad or empty frame never disturbs either held reading
  a_bad_frame_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (!crc_ok || missing)) |=> ($stable(held_hum_q) && $stable(held_temp_q)))
    else $error("held reading changed on a rejected frame");

  // a temperature frame leaves the humidity reading alone
  a_temp_keeps_hum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (kind == KIND_TEMPERATURE)) |=> $stable(held_hum_q))
    else $error("humidity reading changed on a temperature frame");

  // a humidity frame leaves the temperature reading alone
  a_hum_keeps_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (kind == KIND_HUMIDITY)) |=> $stable(held_temp_q))
    else $error("temperature reading changed on a humidity frame");

  // result shows the held value of its kind when nothing was taken meanwhile
  a_result_matches_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_fire) && !$past(!rst_ni) |->
      (out_value_q == (out_kind_q ? held_temp_q[ValueW-1:0] : held_hum_q[ValueW-1:0])))
    else $error("result value differs from held reading");

endmodule
